### design/tcmos_pkg.sv
package tcmos_pkg;

  localparam int unsigned SAMPLE_COUNT_DEF = 10;
  localparam int unsigned RAW_W            = 10;
  localparam int unsigned SMP_W            = 8;
  localparam int unsigned CH_N             = 3;
  localparam int unsigned IN_TDATA_W       = 32;
  localparam int unsigned OUT_TDATA_W      = 24;
  localparam int unsigned WORD_W           = CH_N * SMP_W;

  // floor(x * 255 / 1023) as a reciprocal multiply with a rounding bias
  localparam int unsigned SCALE_MUL = 261375;
  localparam int unsigned SCALE_RND = 1024;
  localparam int unsigned SCALE_SH  = 20;
  localparam int unsigned PROD_W    = 28;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_WRITE,
    ST_RD_PIV,
    ST_LD_PIV,
    ST_RD_CMP,
    ST_CMP,
    ST_CHECK,
    ST_EMIT
  } state_t;

  function automatic logic [SMP_W-1:0] scale(input logic [RAW_W-1:0] x);
    logic [PROD_W-1:0] p;
    p = PROD_W'(x) * PROD_W'(SCALE_MUL) + PROD_W'(SCALE_RND);
    return p[SCALE_SH +: SMP_W];
  endfunction

endpackage

### design/tcmos_ram.sv
module tcmos_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  assign rdata = rd_data_r;

endmodule

### design/three_channel_median_of_samples.sv
// Batch median of three light-sensor channels. Each input transaction carries three
// 10-bit readings (right, middle, left); each is scaled to 8 bits as floor(x*255/1023)
// by one shared multiplier, one channel per cycle, and stored in a small RAM. After an
// ordinary sample is accepted, in_tready stays low while it is scaled and written, so
// the next one waits for idle. When SAMPLE_COUNT samples are held, the block finds the
// median of each channel (the element at index SAMPLE_COUNT/2 of the ascending order,
// so the upper median for even counts) by ranking every stored sample against all
// others through one RAM read port and one three-lane comparator,
// then an emit step, held while the previous result still sits in the output register.
// One result transaction is then produced and a new batch starts. The output register
// lets the next sample be taken while a result waits.
module three_channel_median_of_samples #(
  parameter int unsigned SAMPLE_COUNT = tcmos_pkg::SAMPLE_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // right_raw [9:0], middle_raw [19:10], left_raw [29:20], zero [31:30]
  input  logic [tcmos_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // right_median [7:0], middle_median [15:8], left_median [23:16]
  output logic [tcmos_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int unsigned AW     = $clog2(SAMPLE_COUNT);
  localparam int unsigned SMP_W  = tcmos_pkg::SMP_W;
  localparam int unsigned RAW_W  = tcmos_pkg::RAW_W;
  localparam int unsigned CH_N   = tcmos_pkg::CH_N;
  localparam int unsigned WORD_W = tcmos_pkg::WORD_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(SAMPLE_COUNT - 1);
  localparam logic [AW-1:0] MED_IDX  = AW'(SAMPLE_COUNT / 2);

  tcmos_pkg::state_t state_r, state_nxt;

  logic [CH_N*RAW_W-1:0] raw_r;
  logic [1:0]            ch_r;
  logic [WORD_W-1:0]     smp_r;
  logic [AW-1:0]         cnt_r;
  logic [AW-1:0]         i_r;
  logic [AW-1:0]         j_r;
  logic [WORD_W-1:0]     piv_r;
  logic [AW-1:0]         rank_r [CH_N];
  logic [WORD_W-1:0]     med_r;
  logic                  out_valid_r;
  logic [WORD_W-1:0]     out_data_r;

  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  logic [WORD_W-1:0]     ram_rdata;
  logic [RAW_W-1:0]      raw_sel;
  logic [SMP_W-1:0]      scaled;
  logic                  out_free;

  tcmos_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SAMPLE_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r),
    .wdata (smp_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared scaling unit
  always_comb begin
    case (ch_r)
      2'd0:    raw_sel = raw_r[0 +: RAW_W];
      2'd1:    raw_sel = raw_r[RAW_W +: RAW_W];
      2'd2:    raw_sel = raw_r[2*RAW_W +: RAW_W];
      default: raw_sel = raw_r[0 +: RAW_W];
    endcase
    scaled = tcmos_pkg::scale(raw_sel);
  end

  assign out_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcmos_pkg::ST_IDLE:   if (in_tvalid) state_nxt = tcmos_pkg::ST_SCALE;
      tcmos_pkg::ST_SCALE:  if (ch_r == 2'd2) state_nxt = tcmos_pkg::ST_WRITE;
      tcmos_pkg::ST_WRITE: begin
        state_nxt = (cnt_r == LAST_IDX) ? tcmos_pkg::ST_RD_PIV : tcmos_pkg::ST_IDLE;
      end
      tcmos_pkg::ST_RD_PIV: state_nxt = tcmos_pkg::ST_LD_PIV;
      tcmos_pkg::ST_LD_PIV: state_nxt = tcmos_pkg::ST_RD_CMP;
      tcmos_pkg::ST_RD_CMP: state_nxt = tcmos_pkg::ST_CMP;
      tcmos_pkg::ST_CMP: begin
        state_nxt = (j_r == LAST_IDX) ? tcmos_pkg::ST_CHECK : tcmos_pkg::ST_RD_CMP;
      end
      tcmos_pkg::ST_CHECK: begin
        state_nxt = (i_r == LAST_IDX) ? tcmos_pkg::ST_EMIT : tcmos_pkg::ST_RD_PIV;
      end
      tcmos_pkg::ST_EMIT:   if (out_free) state_nxt = tcmos_pkg::ST_IDLE;
      default:              state_nxt = tcmos_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = j_r;
    unique case (state_r)
      tcmos_pkg::ST_IDLE:   in_tready = 1'b1;
      tcmos_pkg::ST_WRITE:  ram_we = 1'b1;
      tcmos_pkg::ST_RD_PIV: ram_raddr = i_r;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcmos_pkg::ST_IDLE;
      ch_r        <= '0;
      cnt_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == tcmos_pkg::ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        tcmos_pkg::ST_IDLE: begin
          raw_r <= in_tdata[CH_N*RAW_W-1:0];
          ch_r  <= '0;
        end
        tcmos_pkg::ST_SCALE: begin
          for (int l = 0; l < CH_N; l++) begin
            if (ch_r == 2'(l)) begin
              smp_r[l*SMP_W +: SMP_W] <= scaled;
            end
          end
          ch_r <= ch_r + 2'd1;
        end
        tcmos_pkg::ST_WRITE: begin
          cnt_r <= (cnt_r == LAST_IDX) ? '0 : cnt_r + AW'(1);
          i_r   <= '0;
        end
        tcmos_pkg::ST_LD_PIV: begin
          piv_r <= ram_rdata;
          j_r   <= '0;
          for (int l = 0; l < CH_N; l++) begin
            rank_r[l] <= '0;
          end
        end
        tcmos_pkg::ST_CMP: begin
          // stable rank: smaller values, or equal values stored earlier
          for (int l = 0; l < CH_N; l++) begin
            if ((ram_rdata[l*SMP_W +: SMP_W] < piv_r[l*SMP_W +: SMP_W]) ||
                ((ram_rdata[l*SMP_W +: SMP_W] == piv_r[l*SMP_W +: SMP_W]) && (j_r < i_r))) begin
              rank_r[l] <= rank_r[l] + AW'(1);
            end
          end
          j_r <= j_r + AW'(1);
        end
        tcmos_pkg::ST_CHECK: begin
          for (int l = 0; l < CH_N; l++) begin
            if (rank_r[l] == MED_IDX) begin
              med_r[l*SMP_W +: SMP_W] <= piv_r[l*SMP_W +: SMP_W];
            end
          end
          i_r <= i_r + AW'(1);
        end
        tcmos_pkg::ST_EMIT: begin
          if (out_free) begin
            out_data_r <= med_r;
          end
        end
        default: begin
          ch_r <= ch_r;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a new result only comes out of the emit step
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid ##1 out_tvalid) |-> $past(state_r == tcmos_pkg::ST_EMIT))
    else $error("result raised outside emit step");

  // sample count stays inside the batch
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_IDX)
    else $error("sample count out of range");

  // a sort pass only starts with a full batch in the store
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcmos_pkg::ST_WRITE && cnt_r == LAST_IDX) |=>
      (state_r == tcmos_pkg::ST_RD_PIV && i_r == '0 && cnt_r == '0))
    else $error("sort entered without a full batch");

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned RAW_W       = tcmos_pkg::RAW_W;
  localparam int unsigned SMP_W       = tcmos_pkg::SMP_W;
  localparam int unsigned IN_TDATA_W  = tcmos_pkg::IN_TDATA_W;
  localparam int unsigned OUT_TDATA_W = tcmos_pkg::OUT_TDATA_W;
  localparam int unsigned BATCH_LEN  = tcmos_pkg::SAMPLE_COUNT_DEF;
  localparam int unsigned RAND_BATCH = 163;
  localparam int unsigned HOLD_AT    = 600;
  localparam int unsigned HOLD_LEN   = 3000;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned TAIL_WAIT  = 300;

  typedef enum int {MODE_UNIFORM, MODE_EXTREME, MODE_CLUSTER, MODE_REPEAT} batch_mode_t;

  typedef struct {
    logic [RAW_W-1:0] right;
    logic [RAW_W-1:0] middle;
    logic [RAW_W-1:0] left;
    bit               drain;
  } sample_t;

  typedef struct {
    logic [SMP_W-1:0] right;
    logic [SMP_W-1:0] middle;
    logic [SMP_W-1:0] left;
  } medians_t;

  typedef logic [SMP_W-1:0] chan_t [BATCH_LEN];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  sample_t  pending_samples[$];
  medians_t median_queue[$];

  chan_t right_buf;
  chan_t middle_buf;
  chan_t left_buf;
  int unsigned held = 0;

  int unsigned errors = 0;
  int unsigned in_count = 0;
  int unsigned out_count = 0;
  int unsigned batches = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned phase_left = 0;
  int unsigned ready_pct = 100;
  bit          in_fire = 1'b0;

  always #1 clk = ~clk;

  three_channel_median_of_samples u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    // right_raw [9:0], middle_raw [19:10], left_raw [29:20], zero [31:30]
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // right_median [7:0], middle_median [15:8], left_median [23:16]
    .out_tdata  (out_tdata)
  );

  function automatic logic [SMP_W-1:0] scale8(input logic [RAW_W-1:0] x);
    int unsigned p;
    p = (int'(x) * 255) / 1023;
    return p[SMP_W-1:0];
  endfunction

  function automatic logic [SMP_W-1:0] mid_of(input chan_t vals);
    chan_t s;
    logic [SMP_W-1:0] v;
    int j;
    s = vals;
    for (int i = 1; i < BATCH_LEN; i++) begin
      v = s[i];
      j = i;
      while (j > 0 && s[j-1] > v) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = v;
    end
    return s[BATCH_LEN/2];
  endfunction

  task automatic predict_sample(input logic [IN_TDATA_W-1:0] word);
    medians_t med;
    right_buf[held]  = scale8(word[9:0]);
    middle_buf[held] = scale8(word[19:10]);
    left_buf[held]   = scale8(word[29:20]);
    held++;
    if (held == BATCH_LEN) begin
      med.right  = mid_of(right_buf);
      med.middle = mid_of(middle_buf);
      med.left   = mid_of(left_buf);
      median_queue.push_back(med);
      held = 0;
      batches++;
    end
  endtask

  task automatic report(input string what, input int exp_v, input int got_v);
    $display("error: %s expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
    errors++;
  endtask

  function automatic logic [RAW_W-1:0] gen_raw(input batch_mode_t mode, input int base,
                                                input logic [RAW_W-1:0] pool0,
                                                input logic [RAW_W-1:0] pool1);
    int v;
    case (mode)
      MODE_EXTREME: begin
        case ($urandom_range(0, 3))
          0: v = 0;
          1: v = 1;
          2: v = 1022;
          default: v = 1023;
        endcase
      end
      MODE_CLUSTER: begin
        v = base + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
      end
      MODE_REPEAT: begin
        v = $urandom_range(0, 1) ? int'(pool0) : int'(pool1);
      end
      default: v = $urandom_range(0, 1023);
    endcase
    return v[RAW_W-1:0];
  endfunction

  task automatic queue_sample(input int r, input int m, input int l, input bit drain);
    sample_t s;
    s.right  = r[RAW_W-1:0];
    s.middle = m[RAW_W-1:0];
    s.left   = l[RAW_W-1:0];
    s.drain  = drain;
    pending_samples.push_back(s);
  endtask

  // sender: bursts with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      in_tvalid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left  <= gap_left - 1;
      in_tvalid <= 1'b0;
    end else if (pending_samples.size() == 0) begin
      in_tvalid <= 1'b0;
    end else if (pending_samples[0].drain && median_queue.size() != 0) begin
      in_tvalid <= 1'b0;
    end else begin
      in_tdata  <= {2'b00, pending_samples[0].left, pending_samples[0].middle,
                    pending_samples[0].right};
      in_tvalid <= 1'b1;
      void'(pending_samples.pop_front());
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        case ($urandom_range(0, 3))
          0: gap_left <= 0;
          1: gap_left <= $urandom_range(20, 80);
          default: gap_left <= $urandom_range(1, 12);
        endcase
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // receiver: random ready pattern in phases, one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && in_count >= HOLD_AT) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_LEN;
      out_tready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        phase_left <= $urandom_range(20, 300);
        case ($urandom_range(0, 3))
          0: ready_pct <= 100;
          1: ready_pct <= 75;
          2: ready_pct <= 40;
          default: ready_pct <= 10;
        endcase
      end else begin
        phase_left <= phase_left - 1;
      end
      out_tready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin
    medians_t want;
    if (rst_n) begin
      in_fire <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        predict_sample(in_tdata);
        in_count++;
      end
      if (out_tvalid && out_tready) begin
        out_count++;
        if (median_queue.size() == 0) begin
          report("unexpected result transaction", 0, out_tdata);
        end else begin
          want = median_queue.pop_front();
          if (out_tdata[7:0] != want.right) report("right_median", want.right, out_tdata[7:0]);
          if (out_tdata[15:8] != want.middle)
            report("middle_median", want.middle, out_tdata[15:8]);
          if (out_tdata[23:16] != want.left)
            report("left_median", want.left, out_tdata[23:16]);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("three_channel_median_of_samples: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    batch_mode_t mode;
    int base_r, base_m, base_l;
    logic [RAW_W-1:0] p0, p1;

    // alternating extremes and ramps
    for (int i = 0; i < BATCH_LEN; i++)
      queue_sample((i % 2) ? 1023 : 0, (i * 113) % 1024, 1023 - ((i * 113) % 1024), 1'b0);
    // walking ones and zeros, constant full scale
    for (int i = 0; i < BATCH_LEN; i++)
      queue_sample(1023, 1 << (i % RAW_W), 1023 ^ (1 << (i % RAW_W)), i == 0);

    for (int b = 0; b < RAND_BATCH; b++) begin
      mode   = batch_mode_t'($urandom_range(0, 3));
      base_r = $urandom_range(0, 1023);
      base_m = $urandom_range(0, 1023);
      base_l = $urandom_range(0, 1023);
      p0     = $urandom_range(0, 1023);
      p1     = $urandom_range(0, 1023);
      for (int i = 0; i < BATCH_LEN; i++)
        queue_sample(gen_raw(mode, base_r, p0, p1), gen_raw(mode, base_m, p1, p0),
                     gen_raw(mode, base_l, p0, p1),
                     (i == 0) && (b == 0 || $urandom_range(0, 19) == 0));
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_samples.size() != 0 || in_tvalid) @(posedge clk);
    while (median_queue.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("run covered %0d sample transactions in %0d batches, %0d median results",
             in_count, batches, out_count);
    $display("traffic mixed bursty input with a %0d-cycle output hold-off", HOLD_LEN);
    if (errors == 0) begin
      $display("three_channel_median_of_samples: match");
    end else begin
      $display("three_channel_median_of_samples: mismatch");
    end
    $finish;
  end

endmodule
